@@ rtl/mdc_pkg.sv @@
// Shared types and constants for the motorised door controller.
`default_nettype none
package mdc_pkg;

    typedef enum logic [2:0] {
        MODE_UNKNOWN = 3'd0,
        MODE_OPENING = 3'd1,
        MODE_OPENED  = 3'd2,
        MODE_CLOSING = 3'd3,
        MODE_CLOSED  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_OPEN  = 2'd1,
        FUNC_CLOSE = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        DIR_STOP    = 2'd0,
        DIR_FORWARD = 2'd1,
        DIR_REVERSE = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        CFG_OPEN_SPEED  = 2'd0,
        CFG_CLOSE_SPEED = 2'd1,
        CFG_MAX_TRAVEL  = 2'd2,
        CFG_BLANK       = 2'd3
    } t_cfg_idx;

    typedef logic [7:0]  t_speed;
    typedef logic [15:0] t_ticks;
    typedef logic [15:0] t_cfg_data;

    localparam t_speed OPEN_SPEED_RST  = 8'd200;
    localparam t_speed CLOSE_SPEED_RST = 8'd75;
    localparam t_ticks MAX_TRAVEL_RST  = 16'd10000;
    localparam t_ticks BLANK_RST       = 16'd500;
    localparam t_ticks TICKS_MAX       = 16'hFFFF;

endpackage
`default_nettype wire

@@ rtl/mdc_in_if.sv @@
// Request channel: tick, open or close items with switch samples.
`default_nettype none
interface mdc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic       stopper;
    logic       path_clear;

    modport source (output valid, output func, output stopper, output path_clear,
                    input ready);
    modport sink   (input valid, input func, input stopper, input path_clear,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/mdc_out_if.sv @@
// Result channel: door state, motor drive and travel report.
`default_nettype none
interface mdc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  door_state;
    logic [1:0]  motor_dir;
    logic [7:0]  motor_speed;
    logic        travel_done;
    logic [15:0] travel_ticks;

    modport source (output valid, output door_state, output motor_dir,
                    output motor_speed, output travel_done, output travel_ticks,
                    input ready);
    modport sink   (input valid, input door_state, input motor_dir,
                    input motor_speed, input travel_done, input travel_ticks,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/motorized_door_controller_unit.sv @@
// Motorised door controller top level: travel state machine and result register.
// Each accepted item passes through the input register, then the result register;
//   the result stays there until the sink takes it.
// Throughput: one item per cycle while the sink takes each result; a stalled sink holds it.
// Reset (i_rst_n low, synchronous): door unknown, travel and blanking counters
//   cleared, registers back to their defaults, both pipeline stages emptied.
`default_nettype none
module motorized_door_controller_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  mdc_pkg::t_cfg_idx    i_cfg_idx,
    input  mdc_pkg::t_cfg_data   i_cfg_data,
    mdc_in_if.sink               i_cmd,
    mdc_out_if.source            o_res
);
    import mdc_pkg::*;

    // Configuration registers
    t_speed r_open_speed;
    t_speed r_close_speed;
    t_ticks r_max_travel;
    t_ticks r_blank;

    // Input stage
    logic   r_in_valid;
    t_func  r_func;
    logic   r_stopper;
    logic   r_path_clear;

    // Door state
    t_mode  r_mode, n_mode;
    t_ticks r_elapsed, n_elapsed;
    t_ticks r_blank_left, n_blank_left;

    // Result stage
    logic   r_out_valid;
    t_mode  r_res_mode;
    t_dir   r_res_dir,  n_dir;
    t_speed r_res_speed, n_speed;
    logic   r_res_done, n_done;
    t_ticks r_res_ticks, n_ticks;

    logic   adv;
    logic   moving;
    logic   do_check;

    // Advance the input stage whenever the result register is free or being taken.
    assign adv         = !r_out_valid || o_res.ready;
    assign i_cmd.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_speed  <= OPEN_SPEED_RST;
            r_close_speed <= CLOSE_SPEED_RST;
            r_max_travel  <= MAX_TRAVEL_RST;
            r_blank       <= BLANK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OPEN_SPEED:  r_open_speed  <= i_cfg_data[7:0];
                CFG_CLOSE_SPEED: r_close_speed <= i_cfg_data[7:0];
                CFG_MAX_TRAVEL:  r_max_travel  <= i_cfg_data;
                CFG_BLANK:       r_blank       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Capture the item; hold it while the result side is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_func       <= t_func'(i_cmd.func);
            r_stopper    <= i_cmd.stopper;
            r_path_clear <= i_cmd.path_clear;
        end
    end

    // Next door state for the item in the input stage.
    always_comb begin
        n_mode       = r_mode;
        n_elapsed    = r_elapsed;
        n_blank_left = r_blank_left;
        n_done       = 1'b0;
        n_ticks      = '0;
        do_check     = 1'b0;
        moving       = (r_mode == MODE_OPENING) || (r_mode == MODE_CLOSING);

        case (r_func)
            FUNC_TICK: begin
                if (moving) begin
                    // Count travel time, saturating; a running blanking window
                    // suppresses the end check until its last tick.
                    if (r_elapsed != TICKS_MAX) begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                    if (r_blank_left != '0) begin
                        n_blank_left = r_blank_left - 16'd1;
                        do_check     = (r_blank_left == 16'd1);
                    end else begin
                        do_check = 1'b1;
                    end
                end
            end
            FUNC_OPEN: begin
                if (!moving && r_mode != MODE_OPENED) begin
                    n_mode       = MODE_OPENING;
                    n_elapsed    = '0;
                    n_blank_left = r_stopper ? r_blank : '0;
                    do_check     = !r_stopper || (r_blank == '0);
                end
            end
            FUNC_CLOSE: begin
                if (!moving && r_mode != MODE_CLOSED) begin
                    n_mode       = MODE_CLOSING;
                    n_elapsed    = '0;
                    n_blank_left = r_stopper ? r_blank : '0;
                    do_check     = !r_stopper || (r_blank == '0);
                end
            end
            default: begin
                // Unused code: no time passes, nothing changes.
            end
        endcase

        // Blocked doorway while closing: turn round into a fresh opening travel.
        if (do_check && n_mode == MODE_CLOSING && !r_path_clear) begin
            n_mode       = MODE_OPENING;
            n_elapsed    = '0;
            n_blank_left = r_stopper ? r_blank : '0;
            do_check     = !r_stopper || (r_blank == '0);
        end

        // Stopper hit or time limit reached: end the travel and report it.
        if (do_check && (n_mode == MODE_OPENING || n_mode == MODE_CLOSING)
                && (r_stopper || n_elapsed >= r_max_travel)) begin
            n_done  = 1'b1;
            n_ticks = n_elapsed;
            n_mode  = (n_mode == MODE_CLOSING) ? MODE_CLOSED : MODE_OPENED;
        end

        // Motor drive follows the new state.
        case (n_mode)
            MODE_OPENING: begin
                n_dir   = DIR_FORWARD;
                n_speed = r_open_speed;
            end
            MODE_CLOSING: begin
                n_dir   = DIR_REVERSE;
                n_speed = r_close_speed;
            end
            default: begin
                n_dir   = DIR_STOP;
                n_speed = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_UNKNOWN;
            r_elapsed    <= '0;
            r_blank_left <= '0;
        end else if (r_in_valid && adv) begin
            r_mode       <= n_mode;
            r_elapsed    <= n_elapsed;
            r_blank_left <= n_blank_left;
        end
    end

    // Result register: load on advance, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && adv) begin
            r_res_mode  <= n_mode;
            r_res_dir   <= n_dir;
            r_res_speed <= n_speed;
            r_res_done  <= n_done;
            r_res_ticks <= n_ticks;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.door_state   = r_res_mode;
    assign o_res.motor_dir    = r_res_dir;
    assign o_res.motor_speed  = r_res_speed;
    assign o_res.travel_done  = r_res_done;
    assign o_res.travel_ticks = r_res_ticks;

    // A running blanking window only exists during travel.
    a_blank_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_blank_left != '0) |-> (r_mode == MODE_OPENING || r_mode == MODE_CLOSING))
        else $error("blanking count left while door is stopped");

    // A finished travel always lands in an end state.
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res_done)
            |-> (r_res_mode == MODE_OPENED || r_res_mode == MODE_CLOSED))
        else $error("travel reported done outside an end state");

    // Travel ticks are reported only with a finished travel.
    a_ticks_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res_done) |-> (r_res_ticks == '0))
        else $error("travel ticks reported without travel done");

    // A stopped motor gets no drive.
    a_stop_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res_dir == DIR_STOP) |-> (r_res_speed == '0))
        else $error("drive level while motor stopped");

    // A state update only happens for an item that moves on to the result register.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> $stable(r_mode) && $stable(r_elapsed))
        else $error("door state changed while stalled");

endmodule
`default_nettype wire
